FILE: design/srlt_pkg.sv
package srlt_pkg;

  localparam int KIND_W      = 3;
  localparam int TABLE_W     = 64;
  localparam int RATE_W      = 32;
  localparam int RATIO_W     = 17;
  localparam int LEVEL_OUT_W = 5;
  localparam int PROD_W      = RATE_W + RATIO_W;
  localparam int FRAC_W      = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic {
    OP_UPGRADE   = 1'b0,
    OP_DOWNGRADE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    OUT_SET    = 2'd0,
    OUT_REMOVE = 2'd1,
    OUT_DROP   = 2'd2
  } outcome_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CUT_RATIO  = 1'b0,
    CFG_FLOOR_RATE = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_SCAN,
    S_UP_MUL,
    S_UP_EVAL,
    S_UP_REC,
    S_UP_DEC,
    S_UP_EMIT,
    S_DG_PUSH,
    S_DG_POP,
    S_DG_CNT,
    S_DG_SEL,
    S_DG_SCAN,
    S_DG_APPLY
  } state_e;

  typedef struct packed {
    op_e                 op;
    logic [KIND_W-1:0]   kind;
    logic [TABLE_W-1:0]  tbl;
    logic [RATE_W-1:0]   meas;
    logic                eos;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [TABLE_W-1:0] tbl;
    logic [RATE_W-1:0]  rate;
  } ent_t;

  function automatic logic key_less(input logic [KIND_W-1:0] ka, input logic [TABLE_W-1:0] ta,
                                    input logic [KIND_W-1:0] kb, input logic [TABLE_W-1:0] tb);
    logic res;
    if (ka != kb) begin
      res = ka < kb;
    end else begin
      res = $signed(ta) < $signed(tb);
    end
    return res;
  endfunction

endpackage

FILE: design/srlt_ram.sv
module srlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/srlt_front.sv
module srlt_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        action_i,
  input  logic [srlt_pkg::KIND_W-1:0] flow_kind_i,
  input  logic [srlt_pkg::TABLE_W-1:0] flow_table_i,
  input  logic [srlt_pkg::RATE_W-1:0] measured_rate_i,
  input  logic                        end_of_snapshot_i,
  output logic                        cmd_valid_o,
  input  logic                        cmd_ready_i,
  output srlt_pkg::cmd_t              cmd_o
);

  // Two-word queue decoupling the input channel from the engine.
  srlt_pkg::cmd_t slot_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     fill_q;
  srlt_pkg::cmd_t cmd_c;
  logic           push, pop;

  always_comb begin
    cmd_c.op   = action_i ? srlt_pkg::OP_DOWNGRADE : srlt_pkg::OP_UPGRADE;
    cmd_c.kind = flow_kind_i;
    cmd_c.tbl  = flow_table_i;
    cmd_c.meas = measured_rate_i;
    cmd_c.eos  = end_of_snapshot_i & ~action_i;
  end

  assign in_ready_o  = (fill_q != 2'd2);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i & in_ready_o;
  assign pop         = cmd_valid_o & cmd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_c;
    end
  end

endmodule

FILE: design/srlt_back.sv
module srlt_back #(
  parameter int TABLE_ENTRIES     = 64,
  parameter int HISTORY_LEVELS    = 16,
  parameter int CHANGES_PER_LEVEL = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [srlt_pkg::RATIO_W-1:0]     cut_ratio_i,
  input  logic [srlt_pkg::RATE_W-1:0]      floor_rate_i,
  input  logic                             cmd_valid_i,
  output logic                             cmd_ready_o,
  input  srlt_pkg::cmd_t                   cmd_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       outcome_o,
  output logic [srlt_pkg::KIND_W-1:0]      out_kind_o,
  output logic [srlt_pkg::TABLE_W-1:0]     out_table_o,
  output logic [srlt_pkg::RATE_W-1:0]      new_rate_limit_o,
  output logic [srlt_pkg::LEVEL_OUT_W-1:0] stack_level_o,
  output logic                             final_result_o
);

  localparam int T   = TABLE_ENTRIES;
  localparam int H   = HISTORY_LEVELS;
  localparam int C   = CHANGES_PER_LEVEL;
  localparam int UD  = H * C;
  localparam int TAW = $clog2(T);
  localparam int UAW = (UD > 1) ? $clog2(UD) : 1;
  localparam int HAW = (H > 1) ? $clog2(H) : 1;
  localparam int CIW = (C > 1) ? $clog2(C) : 1;
  localparam int LW  = $clog2(H + 1);
  localparam int CW  = $clog2(C + 1);
  localparam int TCW = $clog2(T + 1);
  localparam int SW  = (TCW > CW) ? TCW : CW;
  localparam int KW  = srlt_pkg::KIND_W;
  localparam int BW  = srlt_pkg::TABLE_W;
  localparam int RW  = srlt_pkg::RATE_W;
  localparam int FRAC_OFF = srlt_pkg::FRAC_W;

  srlt_pkg::state_e state_q, state_d;

  srlt_pkg::cmd_t   cmd_q;
  logic [KW-1:0]    key_kind_q;
  logic [BW-1:0]    key_tbl_q;
  logic [LW-1:0]    level_q;
  logic [CW-1:0]    open_q;
  logic [T-1:0]     valid_q;

  logic [SW-1:0]    rd_cnt_q, chk_idx_q;
  logic             chk_vld_q;
  logic             hit_q, free_q, rhit_q, min_vld_q;
  logic [TAW-1:0]   hit_idx_q, free_idx_q;
  logic [RW-1:0]    hit_rate_q, old_q, nl_q;
  logic [UAW-1:0]   rhit_addr_q;
  logic [srlt_pkg::PROD_W-1:0] prod_q;
  logic             res_q;
  srlt_pkg::outcome_e res_outcome_q;
  logic [CW-1:0]    cnt_q, emit_q;
  logic [C-1:0]     done_q;
  logic [CIW-1:0]   min_j_q;
  logic [KW-1:0]    min_kind_q;
  logic [BW-1:0]    min_tbl_q;
  logic [RW-1:0]    min_old_q;

  logic             out_valid_q, fin_q;
  srlt_pkg::outcome_e outcome_q;
  logic [KW-1:0]    okind_q;
  logic [BW-1:0]    otbl_q;
  logic [RW-1:0]    orate_q;
  logic [LW-1:0]    olevel_q;

  logic             lim_we, undo_we, cnt_we;
  logic [TAW-1:0]   lim_waddr, lim_raddr;
  logic [UAW-1:0]   undo_waddr, undo_raddr, base;
  logic [HAW-1:0]   cnt_waddr, cnt_raddr;
  srlt_pkg::ent_t   lim_wdata, lim_rdata, undo_wdata, undo_rdata;
  logic [CW-1:0]    cnt_rdata;

  logic             out_free, out_load, fin_c, scan_clr, is_scan_d, do_push, ok_c;
  logic             issue, scan_done, tbl_scan, limiting_c, set_valid, clr_valid;
  logic [SW-1:0]    scan_lim;
  logic [srlt_pkg::PROD_W-FRAC_OFF-1:0] cut_full;
  logic [RW-1:0]    nl_c;
  srlt_pkg::outcome_e out_outcome_c;
  logic [RW-1:0]    out_rate_c;
  logic [LW-1:0]    out_level_c;

  assign base      = UAW'(level_q) * UAW'(C);
  assign out_free  = ~out_valid_q | out_ready_i;
  assign tbl_scan  = (state_q == srlt_pkg::S_UP_SCAN) || (state_q == srlt_pkg::S_DG_SCAN);
  assign scan_lim  = tbl_scan ? SW'(T) :
                     ((state_q == srlt_pkg::S_UP_REC) ? SW'(open_q) : SW'(cnt_q));
  assign issue     = rd_cnt_q < scan_lim;
  assign scan_done = ~issue & ~chk_vld_q;
  assign lim_raddr = TAW'(rd_cnt_q);
  assign undo_raddr = base + UAW'(rd_cnt_q);
  assign cnt_raddr = HAW'(level_q - LW'(1));
  assign fin_c     = (emit_q + CW'(1)) == cnt_q;

  assign cut_full  = prod_q[srlt_pkg::PROD_W-1:FRAC_OFF];
  always_comb begin
    nl_c = cut_full[RW] ? {RW{1'b1}} : cut_full[RW-1:0];
    if (nl_c < floor_rate_i) begin
      nl_c = floor_rate_i;
    end
  end
  assign limiting_c = (nl_c < cmd_q.meas) || (old_q != '0);
  assign ok_c = (rhit_q || (open_q < CW'(C))) && (hit_q || free_q);

  always_comb begin
    state_d       = state_q;
    cmd_ready_o   = 1'b0;
    lim_we        = 1'b0;
    lim_waddr     = hit_q ? hit_idx_q : free_idx_q;
    lim_wdata     = '{kind: key_kind_q, tbl: key_tbl_q, rate: nl_q};
    undo_we       = 1'b0;
    undo_waddr    = rhit_q ? rhit_addr_q : (base + UAW'(open_q));
    undo_wdata    = '{kind: key_kind_q, tbl: key_tbl_q, rate: old_q};
    cnt_we        = 1'b0;
    cnt_waddr     = HAW'(level_q);
    do_push       = 1'b0;
    out_load      = 1'b0;
    set_valid     = 1'b0;
    clr_valid     = 1'b0;
    out_outcome_c = res_outcome_q;
    out_rate_c    = (res_outcome_q == srlt_pkg::OUT_SET) ? nl_q : '0;
    out_level_c   = level_q;
    unique case (state_q)
      srlt_pkg::S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          state_d = (cmd_i.op == srlt_pkg::OP_DOWNGRADE) ? srlt_pkg::S_DG_PUSH
                                                         : srlt_pkg::S_UP_SCAN;
        end
      end
      srlt_pkg::S_UP_SCAN: begin
        if (scan_done) begin
          state_d = srlt_pkg::S_UP_MUL;
        end
      end
      srlt_pkg::S_UP_MUL: begin
        state_d = srlt_pkg::S_UP_EVAL;
      end
      srlt_pkg::S_UP_EVAL: begin
        if (!limiting_c || (level_q >= LW'(H))) begin
          state_d = srlt_pkg::S_UP_EMIT;
        end else begin
          state_d = srlt_pkg::S_UP_REC;
        end
      end
      srlt_pkg::S_UP_REC: begin
        if (scan_done) begin
          state_d = srlt_pkg::S_UP_DEC;
        end
      end
      srlt_pkg::S_UP_DEC: begin
        if (ok_c) begin
          lim_we    = 1'b1;
          undo_we   = 1'b1;
          set_valid = 1'b1;
        end
        state_d = srlt_pkg::S_UP_EMIT;
      end
      srlt_pkg::S_UP_EMIT: begin
        if (!res_q || out_free) begin
          do_push  = cmd_q.eos && (open_q != '0) && (level_q < LW'(H));
          cnt_we   = do_push;
          out_load = res_q;
          out_level_c = do_push ? level_q + LW'(1) : level_q;
          state_d  = srlt_pkg::S_IDLE;
        end
      end
      srlt_pkg::S_DG_PUSH: begin
        do_push = (open_q != '0) && (level_q < LW'(H));
        cnt_we  = do_push;
        state_d = srlt_pkg::S_DG_POP;
      end
      srlt_pkg::S_DG_POP: begin
        state_d = (level_q == '0) ? srlt_pkg::S_IDLE : srlt_pkg::S_DG_CNT;
      end
      srlt_pkg::S_DG_CNT: begin
        state_d = srlt_pkg::S_DG_SEL;
      end
      srlt_pkg::S_DG_SEL: begin
        if (scan_done) begin
          state_d = srlt_pkg::S_DG_SCAN;
        end
      end
      srlt_pkg::S_DG_SCAN: begin
        if (scan_done) begin
          state_d = srlt_pkg::S_DG_APPLY;
        end
      end
      srlt_pkg::S_DG_APPLY: begin
        lim_wdata     = '{kind: key_kind_q, tbl: key_tbl_q, rate: min_old_q};
        out_outcome_c = (min_old_q != '0) ? srlt_pkg::OUT_SET : srlt_pkg::OUT_REMOVE;
        out_rate_c    = min_old_q;
        if (out_free) begin
          out_load = 1'b1;
          if (min_old_q != '0) begin
            lim_we    = hit_q | free_q;
            set_valid = hit_q | free_q;
          end else begin
            clr_valid = hit_q;
          end
          state_d = fin_c ? srlt_pkg::S_IDLE : srlt_pkg::S_DG_SEL;
        end
      end
      default: begin
        state_d = srlt_pkg::S_IDLE;
      end
    endcase
    is_scan_d = (state_d == srlt_pkg::S_UP_SCAN) || (state_d == srlt_pkg::S_UP_REC) ||
                (state_d == srlt_pkg::S_DG_SEL) || (state_d == srlt_pkg::S_DG_SCAN);
    scan_clr  = is_scan_d && (state_d != state_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srlt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      open_q      <= '0;
      valid_q     <= '0;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (do_push) begin
        level_q <= level_q + LW'(1);
        open_q  <= '0;
      end else if ((state_q == srlt_pkg::S_DG_POP) && (level_q != '0)) begin
        level_q <= level_q - LW'(1);
      end
      if ((state_q == srlt_pkg::S_UP_DEC) && ok_c && !rhit_q) begin
        open_q <= open_q + CW'(1);
      end
      if (set_valid) begin
        valid_q[lim_waddr] <= 1'b1;
      end else if (clr_valid) begin
        valid_q[hit_idx_q] <= 1'b0;
      end
      if (scan_clr) begin
        chk_vld_q <= 1'b0;
      end else begin
        chk_vld_q <= is_scan_d & issue;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == srlt_pkg::S_IDLE && cmd_valid_i) begin
      cmd_q      <= cmd_i;
      key_kind_q <= cmd_i.kind;
      key_tbl_q  <= cmd_i.tbl;
    end
    if (scan_clr) begin
      rd_cnt_q  <= '0;
      rhit_q    <= 1'b0;
      min_vld_q <= 1'b0;
      if ((state_d == srlt_pkg::S_UP_SCAN) || (state_d == srlt_pkg::S_DG_SCAN)) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end
    end else begin
      if (issue) begin
        rd_cnt_q <= rd_cnt_q + SW'(1);
      end
      chk_idx_q <= rd_cnt_q;
      if (tbl_scan && chk_vld_q) begin
        if (valid_q[TAW'(chk_idx_q)] && lim_rdata.kind == key_kind_q &&
            lim_rdata.tbl == key_tbl_q) begin
          hit_q      <= 1'b1;
          hit_idx_q  <= TAW'(chk_idx_q);
          hit_rate_q <= lim_rdata.rate;
        end
        if (!valid_q[TAW'(chk_idx_q)] && !free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= TAW'(chk_idx_q);
        end
      end
      if (state_q == srlt_pkg::S_UP_REC && chk_vld_q && undo_rdata.kind == key_kind_q &&
          undo_rdata.tbl == key_tbl_q) begin
        rhit_q      <= 1'b1;
        rhit_addr_q <= base + UAW'(chk_idx_q);
      end
      if (state_q == srlt_pkg::S_DG_SEL && chk_vld_q && !done_q[CIW'(chk_idx_q)] &&
          (!min_vld_q || srlt_pkg::key_less(undo_rdata.kind, undo_rdata.tbl,
                                            min_kind_q, min_tbl_q))) begin
        min_vld_q  <= 1'b1;
        min_j_q    <= CIW'(chk_idx_q);
        min_kind_q <= undo_rdata.kind;
        min_tbl_q  <= undo_rdata.tbl;
        min_old_q  <= undo_rdata.rate;
      end
    end
    if (state_q == srlt_pkg::S_UP_MUL) begin
      old_q  <= hit_q ? hit_rate_q : '0;
      prod_q <= srlt_pkg::PROD_W'((hit_q && hit_rate_q != '0) ? hit_rate_q : cmd_q.meas) *
                srlt_pkg::PROD_W'(cut_ratio_i);
    end
    if (state_q == srlt_pkg::S_UP_EVAL) begin
      nl_q          <= nl_c;
      res_q         <= limiting_c;
      res_outcome_q <= srlt_pkg::OUT_DROP;
    end
    if (state_q == srlt_pkg::S_UP_DEC && ok_c) begin
      res_outcome_q <= srlt_pkg::OUT_SET;
    end
    if (state_q == srlt_pkg::S_DG_CNT) begin
      cnt_q  <= cnt_rdata;
      emit_q <= '0;
      done_q <= '0;
    end
    if (state_q == srlt_pkg::S_DG_SEL && scan_done) begin
      key_kind_q <= min_kind_q;
      key_tbl_q  <= min_tbl_q;
    end
    if (state_q == srlt_pkg::S_DG_APPLY && out_free) begin
      done_q[min_j_q] <= 1'b1;
      emit_q          <= emit_q + CW'(1);
    end
    if (out_load) begin
      outcome_q <= out_outcome_c;
      okind_q   <= key_kind_q;
      otbl_q    <= key_tbl_q;
      orate_q   <= out_rate_c;
      olevel_q  <= out_level_c;
      fin_q     <= (state_q == srlt_pkg::S_DG_APPLY) ? fin_c : 1'b1;
    end
  end

  srlt_ram #(.WIDTH($bits(srlt_pkg::ent_t)), .DEPTH(T)) u_lim_ram (
    .clk_i   (clk_i),
    .we_i    (lim_we),
    .waddr_i (lim_waddr),
    .wdata_i (lim_wdata),
    .raddr_i (lim_raddr),
    .rdata_o (lim_rdata)
  );

  srlt_ram #(.WIDTH($bits(srlt_pkg::ent_t)), .DEPTH(UD)) u_undo_ram (
    .clk_i   (clk_i),
    .we_i    (undo_we),
    .waddr_i (undo_waddr),
    .wdata_i (undo_wdata),
    .raddr_i (undo_raddr),
    .rdata_o (undo_rdata)
  );

  srlt_ram #(.WIDTH(CW), .DEPTH(H)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (open_q),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign outcome_o        = outcome_q;
  assign out_kind_o       = okind_q;
  assign out_table_o      = otbl_q;
  assign new_rate_limit_o = orate_q;
  assign stack_level_o    = srlt_pkg::LEVEL_OUT_W'(olevel_q);
  assign final_result_o   = fin_q;

endmodule

FILE: design/stacked_rate_limit_throttle_top.sv
// Stacked rate-limit throttle. Input words arrive on a valid/ready channel: an upgrade
// entry (action 0) cuts the limit of one flow and logs the old value in the open undo
// record, and a downgrade (action 1) pops the newest record and restores its limits.
// Results leave on a valid/ready channel, one word per affected flow, final_result
// marking the last word of an input; an upgrade that needs no cut yields no word, nor
// does a downgrade with nothing to undo, and a cut that finds no room yields a drop word.
// The user must write the two registers through the plain write port only while the
// block is idle; the block itself does not enforce it. An upgrade searches the limit
// memory sequentially, one entry per cycle. A downgrade picks each restored flow in
// key order by a pass over the record and then looks it up in the limit memory.
// A two-word queue takes new input words while the engine works, and a result register
// holds a word while the receiver stalls; the engine waits until it is taken.
// Reset empties the limit table and the undo stack at once; no clearing pass is needed.
module stacked_rate_limit_throttle_top #(
  parameter int TABLE_ENTRIES     = 64,
  parameter int HISTORY_LEVELS    = 16,
  parameter int CHANGES_PER_LEVEL = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [srlt_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [srlt_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              action_i,
  input  logic [srlt_pkg::KIND_W-1:0]       flow_kind_i,
  input  logic [srlt_pkg::TABLE_W-1:0]      flow_table_i,
  input  logic [srlt_pkg::RATE_W-1:0]       measured_rate_i,
  input  logic                              end_of_snapshot_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        outcome_o,
  output logic [srlt_pkg::KIND_W-1:0]       out_kind_o,
  output logic [srlt_pkg::TABLE_W-1:0]      out_table_o,
  output logic [srlt_pkg::RATE_W-1:0]       new_rate_limit_o,
  output logic [srlt_pkg::LEVEL_OUT_W-1:0]  stack_level_o,
  output logic                              final_result_o
);

  logic [srlt_pkg::RATIO_W-1:0] cut_ratio_q;
  logic [srlt_pkg::RATE_W-1:0]  floor_rate_q;
  logic                         cmd_valid, cmd_ready;
  srlt_pkg::cmd_t               cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_ratio_q  <= srlt_pkg::RATIO_W'(32768);
      floor_rate_q <= '0;
    end else if (cfg_we_i) begin
      unique case (srlt_pkg::cfg_reg_e'(cfg_index_i))
        srlt_pkg::CFG_CUT_RATIO:  cut_ratio_q  <= cfg_data_i[srlt_pkg::RATIO_W-1:0];
        srlt_pkg::CFG_FLOOR_RATE: floor_rate_q <= cfg_data_i[srlt_pkg::RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  srlt_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .action_i          (action_i),
    .flow_kind_i       (flow_kind_i),
    .flow_table_i      (flow_table_i),
    .measured_rate_i   (measured_rate_i),
    .end_of_snapshot_i (end_of_snapshot_i),
    .cmd_valid_o       (cmd_valid),
    .cmd_ready_i       (cmd_ready),
    .cmd_o             (cmd)
  );

  srlt_back #(
    .TABLE_ENTRIES     (TABLE_ENTRIES),
    .HISTORY_LEVELS    (HISTORY_LEVELS),
    .CHANGES_PER_LEVEL (CHANGES_PER_LEVEL)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cut_ratio_i      (cut_ratio_q),
    .floor_rate_i     (floor_rate_q),
    .cmd_valid_i      (cmd_valid),
    .cmd_ready_o      (cmd_ready),
    .cmd_i            (cmd),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .outcome_o        (outcome_o),
    .out_kind_o       (out_kind_o),
    .out_table_o      (out_table_o),
    .new_rate_limit_o (new_rate_limit_o),
    .stack_level_o    (stack_level_o),
    .final_result_o   (final_result_o)
  );

  a_remove_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o == srlt_pkg::OUT_REMOVE |-> new_rate_limit_o == '0)
    else $error("removed limit reported with a nonzero rate");

  a_drop_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o == srlt_pkg::OUT_DROP |-> final_result_o && new_rate_limit_o == '0)
    else $error("dropped entry must be a single final word with zero rate");

  a_no_outcome_three: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !final_result_o |-> outcome_o == srlt_pkg::OUT_SET ||
                                        outcome_o == srlt_pkg::OUT_REMOVE)
    else $error("a non-final word must come from a downgrade");

endmodule

FILE: verif/tb_stacked_rate_limit_throttle_top.sv
`timescale 1ns / 1ps

module tb_stacked_rate_limit_throttle_top;

  localparam int NSLOT = 64;
  localparam int NLVL = 16;
  localparam int NCHG = 16;
  localparam int SETTLE = 1000;
  localparam int HOLD_CYCLES = 3000;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    srlt_pkg::op_e op;
    logic [2:0]   kind;
    logic [63:0]  tbl;
    logic [31:0]  meas;
    logic         eos;
  } flow_word_t;

  typedef struct {
    srlt_pkg::outcome_e oc;
    logic [2:0]   kind;
    logic [63:0]  tbl;
    logic [31:0]  rate;
    logic [4:0]   lvl;
    logic         fin;
  } limit_word_t;

  typedef struct {
    logic [2:0]   kind;
    logic [63:0]  tbl;
  } flow_key_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [srlt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [srlt_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic action = 1'b0;
  logic [2:0] flow_kind = '0;
  logic [63:0] flow_table = '0;
  logic [31:0] measured_rate = '0;
  logic end_of_snapshot = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] outcome;
  logic [2:0] out_kind;
  logic [63:0] out_table;
  logic [31:0] new_rate_limit;
  logic [4:0] stack_level;
  logic final_result;

  stacked_rate_limit_throttle_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .action_i(action), .flow_kind_i(flow_kind), .flow_table_i(flow_table),
    .measured_rate_i(measured_rate), .end_of_snapshot_i(end_of_snapshot),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .outcome_o(outcome), .out_kind_o(out_kind), .out_table_o(out_table),
    .new_rate_limit_o(new_rate_limit), .stack_level_o(stack_level),
    .final_result_o(final_result)
  );

  always #6 clk_i = ~clk_i;

  // Predicted state of the limit table and the undo stack.
  logic [16:0] ratio_q = 17'd32768;
  logic [31:0] floor_q = '0;
  bit          slot_used [NSLOT];
  logic [2:0]  slot_kind [NSLOT];
  logic [63:0] slot_tbl  [NSLOT];
  logic [31:0] slot_rate [NSLOT];
  logic [2:0]  undo_kind_q [NLVL*NCHG];
  logic [63:0] undo_tbl_q  [NLVL*NCHG];
  logic [31:0] undo_old_q  [NLVL*NCHG];
  int          undo_len [NLVL];
  int          levels = 0;
  int          open_len = 0;

  flow_word_t  pending_words [$];
  limit_word_t expected_words [$];
  flow_key_t   key_pool [$];
  int          failures = 0;
  int          cycles = 0;
  bit          no_gaps = 0;
  bit          hold_req = 0;

  function automatic int find_slot(logic [2:0] k, logic [63:0] t);
    for (int i = 0; i < NSLOT; i++)
      if (slot_used[i] && slot_kind[i] == k && slot_tbl[i] == t) return i;
    return -1;
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < NSLOT; i++)
      if (!slot_used[i]) return i;
    return -1;
  endfunction

  function automatic logic [31:0] scaled_rate(logic [31:0] x);
    logic [48:0] p;
    p = ({17'd0, x} * {32'd0, ratio_q}) >> 16;
    return (p > 49'hFFFFFFFF) ? 32'hFFFFFFFF : p[31:0];
  endfunction

  function automatic bit key_before(logic [2:0] ka, logic [63:0] ta,
                                    logic [2:0] kb, logic [63:0] tb);
    if (ka != kb) return ka < kb;
    return $signed(ta) < $signed(tb);
  endfunction

  function automatic void close_record();
    if (open_len > 0 && levels < NLVL) begin
      undo_len[levels] = open_len;
      levels++;
      open_len = 0;
    end
  endfunction

  function automatic void cut_limit(flow_word_t w);
    int idx, r, f, base;
    logic [31:0] old, nl;
    srlt_pkg::outcome_e oc;
    bit hit;
    limit_word_t e;
    idx = find_slot(w.kind, w.tbl);
    old = (idx >= 0) ? slot_rate[idx] : 32'd0;
    nl = (old > 0) ? scaled_rate(old) : scaled_rate(w.meas);
    if (nl < floor_q) nl = floor_q;
    hit = 0;
    oc = srlt_pkg::OUT_DROP;
    if (nl < w.meas || old > 0) begin
      hit = 1;
      if (levels < NLVL) begin
        base = levels * NCHG;
        r = -1;
        f = -1;
        for (int i = 0; i < open_len; i++)
          if (undo_kind_q[base+i] == w.kind && undo_tbl_q[base+i] == w.tbl) r = base + i;
        if (idx < 0) f = free_slot();
        if ((r >= 0 || open_len < NCHG) && (idx >= 0 || f >= 0)) begin
          if (idx < 0) begin
            idx = f;
            slot_used[idx] = 1;
            slot_kind[idx] = w.kind;
            slot_tbl[idx] = w.tbl;
          end
          slot_rate[idx] = nl;
          if (r < 0) begin
            r = base + open_len;
            open_len++;
            undo_kind_q[r] = w.kind;
            undo_tbl_q[r] = w.tbl;
          end
          undo_old_q[r] = old;
          oc = srlt_pkg::OUT_SET;
        end
      end
    end
    if (w.eos) close_record();
    if (hit) begin
      e.oc = oc;
      e.kind = w.kind;
      e.tbl = w.tbl;
      e.rate = (oc == srlt_pkg::OUT_SET) ? nl : 32'd0;
      e.lvl = levels[4:0];
      e.fin = 1'b1;
      expected_words.insert(expected_words.size(), e);
    end
  endfunction

  function automatic void restore_limits();
    int ord [NCHG];
    int base, cnt, tmp, s, idx;
    limit_word_t e;
    close_record();
    if (levels == 0) return;
    levels--;
    base = levels * NCHG;
    cnt = undo_len[levels];
    for (int i = 0; i < cnt; i++) ord[i] = base + i;
    for (int i = 0; i < cnt; i++)
      for (int j = i + 1; j < cnt; j++)
        if (key_before(undo_kind_q[ord[j]], undo_tbl_q[ord[j]],
                       undo_kind_q[ord[i]], undo_tbl_q[ord[i]])) begin
          tmp = ord[i];
          ord[i] = ord[j];
          ord[j] = tmp;
        end
    for (int i = 0; i < cnt; i++) begin
      s = ord[i];
      idx = find_slot(undo_kind_q[s], undo_tbl_q[s]);
      e.kind = undo_kind_q[s];
      e.tbl = undo_tbl_q[s];
      e.lvl = levels[4:0];
      e.fin = (i + 1 == cnt);
      if (undo_old_q[s] > 0) begin
        if (idx < 0) begin
          idx = free_slot();
          if (idx >= 0) begin
            slot_used[idx] = 1;
            slot_kind[idx] = e.kind;
            slot_tbl[idx] = e.tbl;
          end
        end
        if (idx >= 0) slot_rate[idx] = undo_old_q[s];
        e.oc = srlt_pkg::OUT_SET;
        e.rate = undo_old_q[s];
      end else begin
        if (idx >= 0) slot_used[idx] = 0;
        e.oc = srlt_pkg::OUT_REMOVE;
        e.rate = '0;
      end
      expected_words.insert(expected_words.size(), e);
    end
  endfunction

  int send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    flow_word_t w;
    flow_word_t cur;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        cur.op = srlt_pkg::op_e'(action);
        cur.kind = flow_kind;
        cur.tbl = flow_table;
        cur.meas = measured_rate;
        cur.eos = end_of_snapshot;
        if (cur.op == srlt_pkg::OP_DOWNGRADE) restore_limits();
        else cut_limit(cur);
      end
      if (!(in_valid && !in_ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          action <= w.op;
          flow_kind <= w.kind;
          flow_table <= w.tbl;
          measured_rate <= w.meas;
          end_of_snapshot <= w.eos;
          in_valid <= 1'b1;
          send_gap = no_gaps ? 0 : $urandom_range(0, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  int recv_stall = 0;
  int hold_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    limit_word_t e;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word: kind %0d table %h", out_kind, out_table);
          failures++;
        end else begin
          e = expected_words.pop_front();
          if (outcome !== e.oc) begin
            $error("outcome: expected %0d, actual %0d", e.oc, outcome);
            failures++;
          end
          if (out_kind !== e.kind) begin
            $error("out_kind: expected %0d, actual %0d", e.kind, out_kind);
            failures++;
          end
          if (out_table !== e.tbl) begin
            $error("out_table: expected %h, actual %h", e.tbl, out_table);
            failures++;
          end
          if (new_rate_limit !== e.rate) begin
            $error("new_rate_limit: expected %h, actual %h", e.rate, new_rate_limit);
            failures++;
          end
          if (stack_level !== e.lvl) begin
            $error("stack_level: expected %0d, actual %0d", e.lvl, stack_level);
            failures++;
          end
          if (final_result !== e.fin) begin
            $error("final_result: expected %0d, actual %0d", e.fin, final_result);
            failures++;
          end
        end
        recv_stall = no_gaps ? 0 : $urandom_range(0, 9);
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (recv_stall == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_stacked_rate_limit_throttle_top: FAIL");
      $finish;
    end
  end

  task automatic write_reg(srlt_pkg::cfg_reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == srlt_pkg::CFG_CUT_RATIO) ratio_q = val[16:0];
    else floor_q = val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic add_word(srlt_pkg::op_e op, logic [2:0] k, logic [63:0] t,
                          logic [31:0] m, logic eos);
    flow_word_t w;
    w.op = op;
    w.kind = k;
    w.tbl = t;
    w.meas = m;
    w.eos = eos;
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic add_snapshot(int n, bit fresh);
    flow_key_t k;
    for (int i = 0; i < n; i++) begin
      if (fresh) begin
        k.kind = 3'($urandom_range(0, 7));
        k.tbl = {$urandom, $urandom};
      end else begin
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end
      add_word(srlt_pkg::OP_UPGRADE, k.kind, k.tbl, $urandom, i == n - 1);
    end
  endtask

  task automatic random_traffic(int n);
    int sent;
    int pick;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        pick = $urandom_range(1, 6);
        add_snapshot(pick, 0);
        sent += pick;
      end else if (pick < 90) begin
        add_word(srlt_pkg::OP_DOWNGRADE, 3'($urandom), {$urandom, $urandom}, $urandom,
                 1'($urandom));
        sent++;
      end else begin
        add_word(srlt_pkg::OP_UPGRADE, 3'($urandom), {$urandom, $urandom}, $urandom,
                 1'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    flow_key_t k;
    for (int i = 0; i < 24; i++) begin
      k.kind = (i < 8) ? i[2:0] : 3'($urandom_range(0, 7));
      case (i % 6)
        0: k.tbl = 64'h8000000000000000;
        1: k.tbl = 64'h7FFFFFFFFFFFFFFF;
        2: k.tbl = '0;
        3: k.tbl = '1;
        default: k.tbl = {$urandom, $urandom};
      endcase
      key_pool.insert(key_pool.size(), k);
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_word(srlt_pkg::OP_DOWNGRADE, 3'd0, '0, '0, 1'b0);
    add_word(srlt_pkg::OP_UPGRADE, 3'd0, 64'h8000000000000000, 32'hFFFFFFFF, 1'b0);
    add_word(srlt_pkg::OP_UPGRADE, 3'd0, 64'h8000000000000000, 32'h00000010, 1'b0);
    add_word(srlt_pkg::OP_UPGRADE, 3'd7, 64'h7FFFFFFFFFFFFFFF, 32'd1, 1'b0);
    add_word(srlt_pkg::OP_UPGRADE, 3'd4, '0, '0, 1'b1);
    add_word(srlt_pkg::OP_UPGRADE, 3'd5, '1, '0, 1'b1);
    add_word(srlt_pkg::OP_UPGRADE, 3'd2, 64'h1234, 32'h100, 1'b1);
    add_word(srlt_pkg::OP_DOWNGRADE, 3'd0, '0, '0, 1'b1);
    add_word(srlt_pkg::OP_UPGRADE, 3'd6, '1, 32'h5555AAAA, 1'b0);
    add_word(srlt_pkg::OP_UPGRADE, 3'd1, 64'h8000000000000000, 32'hAAAA5555, 1'b0);
    add_word(srlt_pkg::OP_DOWNGRADE, 3'd0, '0, '0, 1'b0);
    add_word(srlt_pkg::OP_DOWNGRADE, 3'd0, '0, '0, 1'b0);
    add_word(srlt_pkg::OP_DOWNGRADE, 3'd0, '0, '0, 1'b0);
    drain();

    write_reg(srlt_pkg::CFG_CUT_RATIO, 32'd65536);
    write_reg(srlt_pkg::CFG_FLOOR_RATE, 32'd0);
    add_snapshot(3, 0);
    add_word(srlt_pkg::OP_UPGRADE, 3'd3, 64'h77, 32'h1000, 1'b1);
    add_word(srlt_pkg::OP_UPGRADE, 3'd3, 64'h77, 32'h1000, 1'b1);
    add_word(srlt_pkg::OP_DOWNGRADE, 3'd0, '0, '0, 1'b0);
    drain();

    write_reg(srlt_pkg::CFG_CUT_RATIO, 32'd32768);
    random_traffic(70);
    drain();

    no_gaps = 1;
    write_reg(srlt_pkg::CFG_CUT_RATIO, 32'd0);
    write_reg(srlt_pkg::CFG_FLOOR_RATE, 32'hFFFFFFFF);
    random_traffic(25);
    drain();

    no_gaps = 0;
    write_reg(srlt_pkg::CFG_CUT_RATIO, $urandom_range(0, 65536));
    write_reg(srlt_pkg::CFG_FLOOR_RATE, $urandom_range(0, 32'h00FFFFFF));
    hold_req = 1;
    random_traffic(30);
    drain();

    write_reg(srlt_pkg::CFG_CUT_RATIO, 32'd32768);
    write_reg(srlt_pkg::CFG_FLOOR_RATE, 32'd0);
    for (int i = 0; i < 5; i++) add_snapshot(17, 1);
    for (int i = 0; i < 12; i++) add_snapshot(1, 0);
    drain();
    for (int i = 0; i < 18; i++)
      add_word(srlt_pkg::OP_DOWNGRADE, 3'($urandom), '0, '0, 1'($urandom));
    drain();

    if (failures == 0) begin
      $display("tb_stacked_rate_limit_throttle_top: PASS");
    end else begin
      $display("tb_stacked_rate_limit_throttle_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
design/srlt_pkg.sv
design/srlt_ram.sv
design/srlt_front.sv
design/srlt_back.sv
design/stacked_rate_limit_throttle_top.sv
verif/tb_stacked_rate_limit_throttle_top.sv
